// ===== design/salc_pkg.sv =====
// shared types and constants for the set-associative lru cache lookup
// no dependencies
package salc_pkg;
  localparam int unsigned SETS_DEF = 256;
  localparam int unsigned WAYS_DEF = 8;
  localparam int unsigned TAG_W    = 62;
  localparam int unsigned ADDR_W   = 64;
  localparam int unsigned CYC_W    = 18;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 16;
  localparam int unsigned QDEPTH   = 2;

  localparam logic [CFG_IDX_W-1:0] REG_OFFSET = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INDEX  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WAYS   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HIT    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MISS   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MOVE   = 3'd5;

  // access after geometry clamping
  typedef struct packed {
    logic              wr;
    logic [ADDR_W-1:0] tag;
    logic [11:0]       set;
    logic [3:0]        ob;
    logic [3:0]        ib;
    logic [4:0]        nw;
  } acc_t;

  typedef enum logic [1:0] {
    ST_CLEAR, ST_IDLE, ST_READ, ST_DONE
  } back_state_e;
endpackage

// ===== design/salc_ram.sv =====
// generic ram, one write and one read port, registered read
// no dependencies
module salc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ===== design/salc_front.sv =====
// front end: address split by clamped geometry, small queue to the back end
// depends on salc_pkg
module salc_front import salc_pkg::*; #(
  parameter int unsigned SETS = SETS_DEF,
  parameter int unsigned WAYS = WAYS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic              mode_i,
  input  logic [ADDR_W-1:0] address_i,
  input  logic [3:0]        offset_bits_i,
  input  logic [3:0]        index_bits_i,
  input  logic [3:0]        ways_in_use_i,
  output logic              full_o,
  output logic              empty_o,
  input  logic              pop_i,
  output acc_t              head_o
);
  localparam int unsigned MAXK = (SETS > 1) ? $clog2(SETS + 1) - 1 : 0;
  acc_t a;
  acc_t q_q [QDEPTH];
  logic rp_q, wp_q;
  logic [1:0] cnt_q;

  always_comb begin
    a = '0;
    a.wr = mode_i;
    a.ob = (offset_bits_i < 4'd2) ? 4'd2 : (offset_bits_i > 4'd12) ? 4'd12 : offset_bits_i;
    a.ib = (32'(index_bits_i) > MAXK) ? 4'(MAXK) : index_bits_i;
    a.nw = (ways_in_use_i == 4'd0) ? 5'd1 :
           (32'(ways_in_use_i) > WAYS) ? 5'(WAYS) : {1'b0, ways_in_use_i};
    a.set = 12'((address_i >> a.ob) & ((64'd1 << a.ib) - 64'd1));
    // offset plus index reaches 20, so the shift amount needs five bits
    a.tag = address_i >> (5'(a.ob) + 5'(a.ib));
  end

  assign full_o  = (cnt_q == 2'(QDEPTH));
  assign empty_o = (cnt_q == 2'd0);
  assign head_o  = q_q[rp_q];

  always_ff @(posedge clk_i) if (push_i) q_q[wp_q] <= a;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rp_q <= 1'b0; wp_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end
endmodule

// ===== design/salc_back.sv =====
// back end: reads one set row, compares ways, picks victim, writes row back
// depends on salc_pkg, salc_ram
module salc_back import salc_pkg::*; #(
  parameter int unsigned SETS = SETS_DEF,
  parameter int unsigned WAYS = WAYS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              empty_i,
  input  acc_t              head_i,
  output logic              pop_o,
  input  logic [9:0]        hit_latency_i,
  input  logic [9:0]        miss_latency_i,
  input  logic [15:0]       block_move_cycles_i,
  output logic              valid_o,
  output logic              hit_o,
  output logic [2:0]        way_o,
  output logic              writeback_o,
  output logic [ADDR_W-1:0] victim_address_o,
  output logic [CYC_W-1:0]  own_cycles_o
);
  localparam int unsigned SW  = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int unsigned WW  = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned RW  = WAYS * WW;
  localparam int unsigned MW  = WAYS * (TAG_W + 2) + RW;

  back_state_e st_q, st_d;
  logic [SW-1:0] clr_q;
  logic [MW-1:0] rd, wd;
  logic [SW-1:0] ra, wa;
  logic we;

  logic [TAG_W-1:0] tg [WAYS];
  logic [WAYS-1:0]  vl, dt;
  logic [WW-1:0]    rk [WAYS];
  logic             hit, wb, done;
  logic [WW-1:0]    w, r0;
  logic [ADDR_W-1:0] va;
  logic [CYC_W-1:0] cyc;

  salc_ram #(.WIDTH(MW), .DEPTH(SETS)) u_ram (
    .clk_i, .we_i(we), .waddr_i(wa), .wdata_i(wd), .raddr_i(ra), .rdata_o(rd));

  assign ra = SW'(head_i.set);

  always_comb begin
    logic found;
    for (int i = 0; i < WAYS; i++) begin
      tg[i] = rd[i*(TAG_W+2) +: TAG_W];
      vl[i] = rd[i*(TAG_W+2) + TAG_W];
      dt[i] = rd[i*(TAG_W+2) + TAG_W + 1];
      rk[i] = rd[WAYS*(TAG_W+2) + i*WW +: WW];
    end
    found = 1'b0; w = '0;
    for (int i = WAYS-1; i >= 0; i--)
      if (5'(i) < head_i.nw && vl[i] && {2'b0, tg[i]} == head_i.tag) begin
        found = 1'b1; w = WW'(i);
      end
    hit = found;
    if (!found) begin
      w = '0;
      for (int i = 1; i < WAYS; i++)
        if (5'(i) < head_i.nw && rk[i] > rk[w]) w = WW'(i);
    end
    r0 = rk[w];
    wb = !found && vl[w] && dt[w];
    va = wb ? ((ADDR_W'(tg[w]) << (5'(head_i.ob) + 5'(head_i.ib))) |
               (ADDR_W'(head_i.set) << head_i.ob)) : '0;
    cyc = found ? CYC_W'(hit_latency_i) :
          CYC_W'(miss_latency_i) + CYC_W'(block_move_cycles_i) +
          (wb ? CYC_W'(block_move_cycles_i) : '0) + CYC_W'(hit_latency_i);
    wd = rd;
    for (int i = 0; i < WAYS; i++)
      if (rk[i] < r0) wd[WAYS*(TAG_W+2) + i*WW +: WW] = rk[i] + WW'(1);
    wd[WAYS*(TAG_W+2) + w*WW +: WW] = '0;
    if (found) begin
      if (head_i.wr) wd[w*(TAG_W+2) + TAG_W + 1] = 1'b1;
    end else begin
      wd[w*(TAG_W+2) +: TAG_W] = head_i.tag[TAG_W-1:0];
      wd[w*(TAG_W+2) + TAG_W] = 1'b1;
      wd[w*(TAG_W+2) + TAG_W + 1] = head_i.wr;
    end
    if (st_q == ST_CLEAR) begin
      wd = '0;
      for (int i = 0; i < WAYS; i++) wd[WAYS*(TAG_W+2) + i*WW +: WW] = WW'(i);
    end
  end

  // clearing pass writes one set per cycle after reset
  always_comb begin
    st_d = st_q; we = 1'b0; wa = ra; pop_o = 1'b0; done = 1'b0;
    unique case (st_q)
      ST_CLEAR: begin
        we = 1'b1; wa = clr_q;
        if (32'(clr_q) == SETS - 1) st_d = ST_IDLE;
      end
      ST_IDLE:  if (!empty_i) st_d = ST_READ;
      ST_READ:  begin
        we = 1'b1; pop_o = 1'b1; done = 1'b1; st_d = ST_DONE;
      end
      ST_DONE:  st_d = ST_IDLE;
      default:  st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_CLEAR; clr_q <= '0; valid_o <= 1'b0;
    end else begin
      st_q <= st_d; valid_o <= done;
      if (st_q == ST_CLEAR) clr_q <= clr_q + SW'(1);
    end
  end

  always_ff @(posedge clk_i) if (done) begin
    hit_o <= hit; way_o <= 3'(w); writeback_o <= wb;
    victim_address_o <= va; own_cycles_o <= cyc;
  end
endmodule

// ===== design/set_assoc_lru_cache_lookup.sv =====
// set-associative write-back lru cache lookup, top level
// depends on salc_pkg, salc_front, salc_back
// An access is taken when start is high and busy low; busy stays high only
// while the two-deep queue between front and back end is full. The back end
// handles one access at a time: registered read of the set row in the idle
// state, compare and write-back of the row in the read state, then a
// turnaround state while the result shows. done_o is registered from the read
// state and stays for exactly one cycle; the result cannot be held off.
// After reset a clearing pass writes all set rows while accesses queue up to two
// deep; configuration writes take effect at once and belong between accesses.
module set_assoc_lru_cache_lookup import salc_pkg::*; #(
  parameter int unsigned SETS = SETS_DEF,
  parameter int unsigned WAYS = WAYS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic                 mode_i,
  input  logic [ADDR_W-1:0]    address_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_DAT_W-1:0] cfg_data_i,
  output logic                 done_o,
  output logic                 hit_o,
  output logic [2:0]           way_o,
  output logic                 writeback_o,
  output logic [ADDR_W-1:0]    victim_address_o,
  output logic [CYC_W-1:0]     own_cycles_o
);
  logic [3:0] ob_q, ib_q, nw_q;
  logic [9:0] hl_q, ml_q;
  logic [15:0] bm_q;
  logic empty, pop;
  acc_t head;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ob_q <= 4'd5; ib_q <= 4'd8; nw_q <= 4'd8;
      hl_q <= 10'd1; ml_q <= 10'd1; bm_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_OFFSET: ob_q <= cfg_data_i[3:0];
        REG_INDEX:  ib_q <= cfg_data_i[3:0];
        REG_WAYS:   nw_q <= cfg_data_i[3:0];
        REG_HIT:    hl_q <= cfg_data_i[9:0];
        REG_MISS:   ml_q <= cfg_data_i[9:0];
        REG_MOVE:   bm_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  salc_front #(.SETS(SETS), .WAYS(WAYS)) u_front (
    .clk_i, .rst_ni, .push_i(start && !busy), .mode_i, .address_i,
    .offset_bits_i(ob_q), .index_bits_i(ib_q), .ways_in_use_i(nw_q),
    .full_o(busy), .empty_o(empty), .pop_i(pop), .head_o(head));

  salc_back #(.SETS(SETS), .WAYS(WAYS)) u_back (
    .clk_i, .rst_ni, .empty_i(empty), .head_i(head), .pop_o(pop),
    .hit_latency_i(hl_q), .miss_latency_i(ml_q), .block_move_cycles_i(bm_q),
    .valid_o(done_o), .hit_o, .way_o, .writeback_o, .victim_address_o, .own_cycles_o);
endmodule

// ===== tb/set_assoc_lru_cache_lookup_test.sv =====
// self-checking testbench for the set-associative lru cache lookup block
// depends on salc_pkg and set_assoc_lru_cache_lookup; predicts every word
// from its own model of tags, valid, dirty and lru ranks
module set_assoc_lru_cache_lookup_test;
  import salc_pkg::*;

  localparam int unsigned NSETS = 256;
  localparam int unsigned NWAYS = 8;
  localparam int unsigned MAX_IB = 8;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE7 = 3'd7;
  localparam bit MODE_READ = 1'b0;
  localparam bit MODE_WRITE = 1'b1;

  typedef struct {
    logic              wr;
    logic [ADDR_W-1:0] addr;
  } access_t;

  typedef struct {
    logic              hit;
    logic [2:0]        way;
    logic              wb;
    logic [ADDR_W-1:0] vaddr;
    logic [CYC_W-1:0]  cyc;
  } lookup_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic                 mode_i = 1'b0;
  logic [ADDR_W-1:0]    address_i = '0;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_DAT_W-1:0] cfg_data_i = '0;
  logic                 done_o;
  logic                 hit_o;
  logic [2:0]           way_o;
  logic                 writeback_o;
  logic [ADDR_W-1:0]    victim_address_o;
  logic [CYC_W-1:0]     own_cycles_o;

  set_assoc_lru_cache_lookup dut (
    .clk_i, .rst_ni, .start, .busy, .mode_i, .address_i,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .done_o, .hit_o, .way_o, .writeback_o, .victim_address_o, .own_cycles_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state
  logic [3:0]        r_offset = 4'd5;
  logic [3:0]        r_index  = 4'd8;
  logic [3:0]        r_ways   = 4'd8;
  logic [9:0]        r_hit    = 10'd1;
  logic [9:0]        r_miss   = 10'd1;
  logic [15:0]       r_move   = 16'd0;
  logic [ADDR_W-1:0] line_tag   [NSETS*NWAYS];
  bit                line_valid [NSETS*NWAYS];
  bit                line_dirty [NSETS*NWAYS];
  int unsigned       age_rank   [NSETS][NWAYS];

  access_t pending_q[$];
  lookup_t lookup_q[$];
  int      errors = 0;

  function automatic void make_recent(int unsigned s, int unsigned w);
    int unsigned r;
    r = age_rank[s][w];
    for (int i = 0; i < NWAYS; i++)
      if (age_rank[s][i] < r) age_rank[s][i]++;
    age_rank[s][w] = 0;
  endfunction

  function automatic lookup_t predict_lookup(access_t a);
    lookup_t     res;
    int unsigned ob, ib, nw, s, base, victim, best;
    logic [ADDR_W-1:0] tg;
    ob = r_offset;
    ib = r_index;
    nw = r_ways;
    if (ob < 2) ob = 2;
    if (ob > 12) ob = 12;
    if (ib > MAX_IB) ib = MAX_IB;
    if (nw < 1) nw = 1;
    if (nw > NWAYS) nw = NWAYS;
    s = (a.addr >> ob) & ((64'd1 << ib) - 1);
    tg = a.addr >> (ob + ib);
    base = s * NWAYS;
    res = '{hit: 1'b0, way: '0, wb: 1'b0, vaddr: '0, cyc: '0};
    for (int w = 0; w < nw; w++) begin
      if (line_valid[base+w] && line_tag[base+w] == tg) begin
        if (a.wr) line_dirty[base+w] = 1'b1;
        make_recent(s, w);
        res.hit = 1'b1;
        res.way = w[2:0];
        res.cyc = CYC_W'(r_hit);
        return res;
      end
    end
    victim = 0;
    best = age_rank[s][0];
    for (int w = 1; w < nw; w++)
      if (age_rank[s][w] > best) begin
        best = age_rank[s][w];
        victim = w;
      end
    make_recent(s, victim);
    res.cyc = CYC_W'(r_miss) + CYC_W'(r_move) + CYC_W'(r_hit);
    if (line_valid[base+victim] && line_dirty[base+victim]) begin
      res.wb = 1'b1;
      res.vaddr = (line_tag[base+victim] << (ob + ib)) | (ADDR_W'(s) << ob);
      res.cyc = res.cyc + CYC_W'(r_move);
    end
    line_tag[base+victim] = tg;
    line_valid[base+victim] = 1'b1;
    line_dirty[base+victim] = a.wr;
    res.way = victim[2:0];
    return res;
  endfunction

  // driver: one word at a time with a random gap before each
  bit      word_held = 1'b0;
  access_t cur;
  int      gap = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) begin
        lookup_q.push_back(predict_lookup(cur));
        word_held = 1'b0;
      end
      if (!word_held) begin
        if (gap > 0) gap--;
        else if (pending_q.size() > 0) begin
          cur = pending_q.pop_front();
          word_held = 1'b1;
          gap = $urandom_range(0, 1) ? 0 : $urandom_range(0, 10);
        end
      end
      start <= word_held;
      mode_i <= cur.wr;
      address_i <= cur.addr;
    end
  end

  function automatic void report_bad(string what, lookup_t e, lookup_t g);
    errors++;
    if (errors <= 10)
      $display("mismatch (%s): exp hit=%0b way=%0d wb=%0b va=%h cyc=%0d, got hit=%0b way=%0d wb=%0b va=%h cyc=%0d",
               what, e.hit, e.way, e.wb, e.vaddr, e.cyc, g.hit, g.way, g.wb, g.vaddr, g.cyc);
  endfunction

  // monitor
  always @(posedge clk_i) begin
    lookup_t got, want;
    if (rst_ni && done_o) begin
      got = '{hit: hit_o, way: way_o, wb: writeback_o, vaddr: victim_address_o,
              cyc: own_cycles_o};
      if (lookup_q.size() == 0) begin
        want = '{hit: 1'bx, way: 'x, wb: 1'bx, vaddr: 'x, cyc: 'x};
        report_bad("unexpected word", want, got);
      end else begin
        want = lookup_q.pop_front();
        if (got.hit !== want.hit || got.way !== want.way || got.wb !== want.wb ||
            got.vaddr !== want.vaddr || got.cyc !== want.cyc)
          report_bad("field", want, got);
      end
    end
  end

  task automatic wait_idle();
    while (pending_q.size() > 0 || word_held || start || lookup_q.size() > 0)
      @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    case (idx)
      REG_OFFSET: r_offset = val[3:0];
      REG_INDEX:  r_index = val[3:0];
      REG_WAYS:   r_ways = val[3:0];
      REG_HIT:    r_hit = val[9:0];
      REG_MISS:   r_miss = val[9:0];
      REG_MOVE:   r_move = val[15:0];
      default: ;
    endcase
  endtask

  task automatic set_geometry(logic [15:0] ob, logic [15:0] ib, logic [15:0] nw,
                              logic [15:0] hl, logic [15:0] ml, logic [15:0] mv);
    write_reg(REG_OFFSET, ob);
    write_reg(REG_INDEX, ib);
    write_reg(REG_WAYS, nw);
    write_reg(REG_HIT, hl);
    write_reg(REG_MISS, ml);
    write_reg(REG_MOVE, mv);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // words mostly from a small pool of tags over two sets, so hits and evictions happen
  task automatic random_words(int n);
    logic [ADDR_W-1:0] pool[24];
    logic [ADDR_W-1:0] a;
    int unsigned ob, ib, sa, sb;
    ob = (r_offset < 2) ? 2 : (r_offset > 12) ? 12 : r_offset;
    ib = (r_index > MAX_IB) ? MAX_IB : r_index;
    sa = $urandom() & ((1 << ib) - 1);
    sb = $urandom() & ((1 << ib) - 1);
    for (int i = 0; i < 24; i++)
      pool[i] = ((rand64() >> (ob + ib)) << (ob + ib)) |
                (ADDR_W'($urandom_range(0, 1) ? sa : sb) << ob);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) < 2) a = rand64();
      else a = pool[$urandom_range(0, $urandom_range(0, 1) ? 9 : 23)] |
               (ADDR_W'($urandom()) & ((64'd1 << ob) - 1));
      pending_q.push_back('{wr: $urandom_range(0, 1), addr: a});
    end
  endtask

  initial begin
    for (int s = 0; s < NSETS; s++)
      for (int w = 0; w < NWAYS; w++) begin
        age_rank[s][w] = w;
        line_valid[s*NWAYS+w] = 1'b0;
        line_dirty[s*NWAYS+w] = 1'b0;
        line_tag[s*NWAYS+w] = '0;
      end
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed at reset settings: extremes, hit on write, dirty eviction in set 0
    pending_q.push_back('{wr: MODE_READ, addr: '0});
    pending_q.push_back('{wr: MODE_WRITE, addr: '0});
    pending_q.push_back('{wr: MODE_READ, addr: '1});
    pending_q.push_back('{wr: MODE_WRITE, addr: '1});
    for (int t = 1; t <= 9; t++)
      pending_q.push_back('{wr: MODE_WRITE, addr: ADDR_W'(t) << 13});
    pending_q.push_back('{wr: MODE_READ, addr: '0});
    pending_q.push_back('{wr: MODE_READ, addr: 64'h1f});
    pending_q.push_back('{wr: MODE_READ, addr: ADDR_W'(2) << 13});
    pending_q.push_back('{wr: MODE_WRITE, addr: 64'haaaa_aaaa_aaaa_aaaa});
    pending_q.push_back('{wr: MODE_READ, addr: 64'h5555_5555_5555_5555});
    random_words(100);
    wait_idle();

    // fully associative, one way, zero cost; a stale multi-match follows
    set_geometry(16'd2, 16'd0, 16'd1, 16'd0, 16'd0, 16'd0);
    random_words(100);
    wait_idle();
    set_geometry(16'd12, 16'd8, 16'd8, 16'd1023, 16'd1023, 16'd65535);
    random_words(100);
    wait_idle();
    // out of range values clamp
    set_geometry(16'hfff0, 16'h000f, 16'h0000, 16'hfc00, 16'hffff, 16'h8000);
    random_words(100);
    wait_idle();
    set_geometry(16'd15, 16'd9, 16'd15, 16'd3, 16'd7, 16'd20);
    write_reg(REG_SPARE6, 16'hffff);
    write_reg(REG_SPARE7, 16'h1234);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    random_words(100);
    wait_idle();
    for (int p = 0; p < 3; p++) begin
      set_geometry($urandom(), $urandom_range(0, 9), $urandom_range(0, 9),
                   $urandom(), $urandom(), $urandom());
      random_words(100);
      wait_idle();
    end

    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("set_assoc_lru_cache_lookup_test passed");
    end else begin
      $display("set_assoc_lru_cache_lookup_test failed");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("set_assoc_lru_cache_lookup_test failed");
    $finish;
  end
endmodule

// ===== set_assoc_lru_cache_lookup.f =====
design/salc_pkg.sv
design/salc_ram.sv
design/salc_front.sv
design/salc_back.sv
design/set_assoc_lru_cache_lookup.sv
tb/set_assoc_lru_cache_lookup_test.sv
